// ===== rtl/symbol_ngram_histogram_macros.svh =====
// Assertion macros for the n-gram histogram block.
// Included by symbol_ngram_histogram for its assertions; clocked on aclk, reset by aresetn.
`ifndef SYMBOL_NGRAM_HISTOGRAM_MACROS_SVH
`define SYMBOL_NGRAM_HISTOGRAM_MACROS_SVH
`ifndef ASSERT_OFF
`define SNH_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SNH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`define SNH_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);
`else
`define SNH_ASSERT_IMPLY(lbl, ante, cons, msg)
`define SNH_ASSERT_NEXT(lbl, ante, cons, msg)
`define SNH_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== rtl/snh_pkg.sv =====
// Shared types and constants for the n-gram histogram block.
// No dependencies; used by snh_count_ram, symbol_ngram_histogram and the testbench.
package snh_pkg;

    localparam int SYM_BITS      = 6;
    localparam int KIND_BITS     = 2;
    localparam int CFG_BITS      = 16;
    localparam int HIT_BITS      = 16;
    localparam int S_TDATA_BITS  = 24;
    localparam int S_TUSER_BITS  = 3;
    localparam int M_TDATA_BITS  = 24;
    localparam int M_PAD_BITS    = M_TDATA_BITS - HIT_BITS - 1;
    localparam int MAX_ADDR_BITS = 3 * SYM_BITS;

    localparam logic [CFG_BITS-1:0] THRESH_RESET = 16'd2;
    localparam logic [HIT_BITS-1:0] HIT_MAX      = 16'hFFFF;

    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_UNIGRAM = 2'd0,
        KIND_DIGRAM  = 2'd1,
        KIND_TRIGRAM = 2'd2,
        KIND_REPEAT  = 2'd3
    } kind_t;

    typedef struct packed {
        logic                     wr_en;
        logic [MAX_ADDR_BITS-1:0] wr_addr;
        logic                     rd_en;
        logic [MAX_ADDR_BITS-1:0] rd_addr;
    } mem_req_t;

endpackage

// ===== rtl/snh_count_ram.sv =====
// Single-port-write, single-port-read count memory with registered read data.
// Depends on snh_pkg for the request struct.
module snh_count_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 16
) (
    input  logic                 aclk,
    input  snh_pkg::mem_req_t    req,
    input  logic [DATA_BITS-1:0] wr_data,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem_reg [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr[ADDR_BITS-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem_reg[req.rd_addr[ADDR_BITS-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/symbol_ngram_histogram.sv =====
// Top level of the n-gram histogram: sequencer, history and result register.
// Depends on snh_pkg, snh_count_ram and symbol_ngram_histogram_macros.svh.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata 24b, s_tuser 3b
//  m_      | out       | m_tvalid/m_tready  | m_tdata 24b
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_data 16b (hit threshold)
//
// A push is accepted and read in S_IDLE, then takes a read-modify-write state (S_UNI, S_DI,
// S_REP) per small-memory table touched (unigram, digram, repeat); trigram shares the first.
// A query reads in S_IDLE and loads the result in S_QRY, waiting while m_tready holds the previous result.
// After reset a clearing pass over every big-memory address zeroes both memories; s_tready
// stays low meanwhile, cfg writes are taken at all times.
`include "symbol_ngram_histogram_macros.svh"
module symbol_ngram_histogram #(
    parameter int SYMBOLS    = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // symbol, index_first, index_second, index_third
    input  logic [snh_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // action, table_kind
    input  logic [snh_pkg::S_TUSER_BITS-1:0]  s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit_count, is_hit, zero padding
    output logic [snh_pkg::M_TDATA_BITS-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [snh_pkg::CFG_BITS-1:0]      cfg_data
);

    localparam int SW       = $clog2(SYMBOLS);
    localparam int BIG_AW   = 3 * SW;
    localparam int SMALL_AW = 2 * SW + 1;
    localparam int SB       = snh_pkg::SYM_BITS;
    localparam logic [SB:0] SYM_LIMIT = (SB + 1)'(SYMBOLS);
    localparam logic [1:0]  SEEN_FULL = 2'd2;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_UNI   = 6'b000100,
        S_DI    = 6'b001000,
        S_REP   = 6'b010000,
        S_QRY   = 6'b100000
    } state_t;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
        bump = (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
    endfunction

    state_t                  state_reg, state_next;
    logic [BIG_AW-1:0]       clr_reg, clr_next;
    logic [1:0]              seen_reg, seen_next;
    logic [SW-1:0]           last_reg, last_next;
    logic [SW-1:0]           prev_reg, prev_next;
    logic [snh_pkg::CFG_BITS-1:0] thresh_reg, thresh_next;
    logic                    m_valid_reg, m_valid_next;
    logic [snh_pkg::HIT_BITS-1:0] m_count_reg, m_count_next;
    logic                    m_hit_reg, m_hit_next;

    logic [SMALL_AW-1:0]     uni_addr_reg, di_addr_reg, rep_addr_reg;
    logic [BIG_AW-1:0]       tri_addr_reg;
    logic                    do_di_reg, do_rep_reg, do_tri_reg;
    logic                    q_big_reg, q_ok_reg;

    snh_pkg::action_t        in_action;
    snh_pkg::kind_t          in_kind;
    logic [SB-1:0]           in_sym, in_a, in_b, in_c;
    logic [SW-1:0]           sym_s, a_s, b_s, c_s;
    logic                    sym_ok, a_ok, b_ok, c_ok;
    logic                    s_accept, push_go, query_go, out_load;
    logic [SMALL_AW-1:0]     p_uni_addr, p_di_addr, p_rep_addr, q_small_addr;
    logic [BIG_AW-1:0]       p_tri_addr, q_big_addr;
    logic                    q_big, q_ok;

    snh_pkg::mem_req_t       small_req, big_req;
    logic [COUNT_BITS-1:0]   small_wdata, big_wdata, small_rd, big_rd;
    logic [COUNT_BITS-1:0]   q_count;
    logic [31:0]             count_wide;

    assign in_action = snh_pkg::action_t'(s_tuser[0]);
    assign in_kind   = snh_pkg::kind_t'(s_tuser[2:1]);
    assign in_sym    = s_tdata[SB-1:0];
    assign in_a      = s_tdata[2*SB-1:SB];
    assign in_b      = s_tdata[3*SB-1:2*SB];
    assign in_c      = s_tdata[4*SB-1:3*SB];
    assign sym_s     = in_sym[SW-1:0];
    assign a_s       = in_a[SW-1:0];
    assign b_s       = in_b[SW-1:0];
    assign c_s       = in_c[SW-1:0];
    assign sym_ok    = {1'b0, in_sym} < SYM_LIMIT;
    assign a_ok      = {1'b0, in_a} < SYM_LIMIT;
    assign b_ok      = {1'b0, in_b} < SYM_LIMIT;
    assign c_ok      = {1'b0, in_c} < SYM_LIMIT;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign push_go   = s_accept && (in_action == snh_pkg::ACT_PUSH) && sym_ok;
    assign query_go  = s_accept && (in_action == snh_pkg::ACT_QUERY);
    assign cfg_ready = 1'b1;

    assign p_uni_addr = {1'b1, SW'(0), sym_s};
    assign p_rep_addr = {1'b1, SW'(1), sym_s};
    assign p_di_addr  = {1'b0, last_reg, sym_s};
    assign p_tri_addr = {prev_reg, last_reg, sym_s};
    assign q_big_addr = {a_s, b_s, c_s};

    always_comb begin
        q_small_addr = '0;
        q_big        = 1'b0;
        q_ok         = 1'b0;
        case (in_kind)
            snh_pkg::KIND_UNIGRAM: begin
                q_small_addr = {1'b1, SW'(0), a_s};
                q_ok         = a_ok;
            end
            snh_pkg::KIND_DIGRAM: begin
                q_small_addr = {1'b0, a_s, b_s};
                q_ok         = a_ok && b_ok;
            end
            snh_pkg::KIND_TRIGRAM: begin
                q_big = 1'b1;
                q_ok  = a_ok && b_ok && c_ok;
            end
            snh_pkg::KIND_REPEAT: begin
                q_small_addr = {1'b1, SW'(1), a_s};
                q_ok         = a_ok;
            end
            default: begin
                q_ok = 1'b0;
            end
        endcase
    end

    // memory requests
    always_comb begin
        small_req   = '0;
        big_req     = '0;
        small_wdata = bump(small_rd);
        big_wdata   = bump(big_rd);
        case (state_reg)
            S_CLEAR: begin
                small_wdata       = '0;
                big_wdata         = '0;
                small_req.wr_en   = 1'b1;
                small_req.wr_addr = snh_pkg::MAX_ADDR_BITS'(clr_reg[SMALL_AW-1:0]);
                big_req.wr_en     = 1'b1;
                big_req.wr_addr   = snh_pkg::MAX_ADDR_BITS'(clr_reg);
            end
            S_IDLE: begin
                if (push_go) begin
                    small_req.rd_en   = 1'b1;
                    small_req.rd_addr = snh_pkg::MAX_ADDR_BITS'(p_uni_addr);
                    big_req.rd_en     = 1'b1;
                    big_req.rd_addr   = snh_pkg::MAX_ADDR_BITS'(p_tri_addr);
                end else if (query_go) begin
                    small_req.rd_en   = !q_big;
                    small_req.rd_addr = snh_pkg::MAX_ADDR_BITS'(q_small_addr);
                    big_req.rd_en     = q_big;
                    big_req.rd_addr   = snh_pkg::MAX_ADDR_BITS'(q_big_addr);
                end
            end
            S_UNI: begin
                small_req.wr_en   = 1'b1;
                small_req.wr_addr = snh_pkg::MAX_ADDR_BITS'(uni_addr_reg);
                small_req.rd_en   = do_di_reg;
                small_req.rd_addr = snh_pkg::MAX_ADDR_BITS'(di_addr_reg);
                big_req.wr_en     = do_tri_reg;
                big_req.wr_addr   = snh_pkg::MAX_ADDR_BITS'(tri_addr_reg);
            end
            S_DI: begin
                small_req.wr_en   = 1'b1;
                small_req.wr_addr = snh_pkg::MAX_ADDR_BITS'(di_addr_reg);
                small_req.rd_en   = do_rep_reg;
                small_req.rd_addr = snh_pkg::MAX_ADDR_BITS'(rep_addr_reg);
            end
            S_REP: begin
                small_req.wr_en   = 1'b1;
                small_req.wr_addr = snh_pkg::MAX_ADDR_BITS'(rep_addr_reg);
            end
            default: begin
                small_req = '0;
            end
        endcase
    end

    snh_count_ram #(
        .ADDR_BITS (SMALL_AW),
        .DATA_BITS (COUNT_BITS)
    ) u_small_ram (
        .aclk    (aclk),
        .req     (small_req),
        .wr_data (small_wdata),
        .rd_data (small_rd)
    );

    snh_count_ram #(
        .ADDR_BITS (BIG_AW),
        .DATA_BITS (COUNT_BITS)
    ) u_big_ram (
        .aclk    (aclk),
        .req     (big_req),
        .wr_data (big_wdata),
        .rd_data (big_rd)
    );

    assign q_count    = q_ok_reg ? (q_big_reg ? big_rd : small_rd) : '0;
    assign count_wide = 32'(q_count);
    assign out_load   = (state_reg == S_QRY) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        seen_next    = seen_reg;
        last_next    = last_reg;
        prev_next    = prev_reg;
        thresh_next  = thresh_reg;
        m_valid_next = m_valid_reg;
        m_count_next = m_count_reg;
        m_hit_next   = m_hit_reg;

        if (cfg_valid && cfg_ready) begin
            thresh_next = cfg_data;
        end

        if (m_tvalid && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + BIG_AW'(1);
                if (clr_reg == {BIG_AW{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (push_go) begin
                    state_next = S_UNI;
                    prev_next  = last_reg;
                    last_next  = sym_s;
                    if (seen_reg != SEEN_FULL) begin
                        seen_next = seen_reg + 2'd1;
                    end
                end else if (query_go) begin
                    state_next = S_QRY;
                end
            end
            S_UNI: begin
                state_next = do_di_reg ? S_DI : S_IDLE;
            end
            S_DI: begin
                state_next = do_rep_reg ? S_REP : S_IDLE;
            end
            S_REP: begin
                state_next = S_IDLE;
            end
            S_QRY: begin
                if (out_load) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    m_count_next = (count_wide > 32'(snh_pkg::HIT_MAX)) ?
                                   snh_pkg::HIT_MAX : count_wide[snh_pkg::HIT_BITS-1:0];
                    m_hit_next   = count_wide >= 32'(thresh_reg);
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            seen_reg    <= '0;
            last_reg    <= '0;
            prev_reg    <= '0;
            thresh_reg  <= snh_pkg::THRESH_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            seen_reg    <= seen_next;
            last_reg    <= last_next;
            prev_reg    <= prev_next;
            thresh_reg  <= thresh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // capture the transaction
    always_ff @(posedge aclk) begin
        m_count_reg <= m_count_next;
        m_hit_reg   <= m_hit_next;
        if (s_accept) begin
            uni_addr_reg <= p_uni_addr;
            di_addr_reg  <= p_di_addr;
            rep_addr_reg <= p_rep_addr;
            tri_addr_reg <= p_tri_addr;
            do_di_reg    <= (seen_reg != 2'd0);
            do_rep_reg   <= (seen_reg != 2'd0) && (last_reg == sym_s);
            do_tri_reg   <= (seen_reg == SEEN_FULL);
            q_big_reg    <= q_big;
            q_ok_reg     <= q_ok;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {snh_pkg::M_PAD_BITS'(0), m_hit_reg, m_count_reg};

    logic tri_push;
    assign tri_push = push_go && (seen_reg == SEEN_FULL);

    `SNH_ASSERT_NEXT(a_tri_written, tri_push, big_req.wr_en, "trigram write missing after push")
    `SNH_ASSERT_IMPLY(a_out_from_query, m_valid_reg && !$past(m_valid_reg), $past(state_reg == S_QRY), "result loaded outside query")
    `SNH_ASSERT_NEVER(a_small_same_addr, small_req.rd_en && small_req.wr_en && (small_req.rd_addr == small_req.wr_addr), "small memory read and write collide")
    `SNH_ASSERT_IMPLY(a_rep_after_di, state_reg == S_REP, $past(state_reg == S_DI), "repeat update without digram update")

endmodule

// ===== tb/symbol_ngram_histogram_checker.sv =====
// Checker for the n-gram histogram: watches the input, result and threshold channels.
// Keeps its own count tables and history, predicts each query reading and compares it.
// Depends on snh_pkg; instantiated beside the block by symbol_ngram_histogram_tb.
module symbol_ngram_histogram_checker
    import snh_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    input  logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,
    input  logic [S_TUSER_BITS-1:0] s_tuser,
    input  logic                    m_tvalid,
    input  logic                    m_tready,
    input  logic [M_TDATA_BITS-1:0] m_tdata,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output int                      fail_count,
    output int                      readings_pending
);

    typedef struct packed {
        logic [HIT_BITS-1:0] count;
        logic                hit;
    } reading_t;

    bit [HIT_BITS-1:0] unigram_tally [1 << SYM_BITS];
    bit [HIT_BITS-1:0] repeat_tally  [1 << SYM_BITS];
    bit [HIT_BITS-1:0] digram_tally  [1 << (2 * SYM_BITS)];
    bit [HIT_BITS-1:0] trigram_tally [1 << (3 * SYM_BITS)];

    logic [CFG_BITS-1:0] hit_threshold;
    logic [SYM_BITS-1:0] last_sym;
    logic [SYM_BITS-1:0] prior_sym;
    int unsigned         symbols_taken;
    reading_t            due_readings [$];

    function automatic logic [HIT_BITS-1:0] bumped(input logic [HIT_BITS-1:0] n);
        return (n == HIT_MAX) ? n : n + 1'b1;
    endfunction

    always @(posedge aclk) begin
        action_t             act;
        kind_t               kind;
        logic [SYM_BITS-1:0] sym;
        logic [SYM_BITS-1:0] first;
        logic [SYM_BITS-1:0] second;
        logic [SYM_BITS-1:0] third;
        reading_t            want;
        reading_t            got;

        if (!aresetn) begin
            hit_threshold = THRESH_RESET;
            last_sym      = '0;
            prior_sym     = '0;
            symbols_taken = 0;
            due_readings.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.count = m_tdata[HIT_BITS-1:0];
                got.hit   = m_tdata[HIT_BITS];
                if (due_readings.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result transaction, count %0d is_hit %b",
                             $time, got.count, got.hit);
                end else begin
                    want = due_readings.pop_front();
                    if (got.count !== want.count) begin
                        fail_count++;
                        $display("%0t: hit_count mismatch, expected %0d, actual %0d",
                                 $time, want.count, got.count);
                    end
                    if (got.hit !== want.hit) begin
                        fail_count++;
                        $display("%0t: is_hit mismatch, expected %b, actual %b",
                                 $time, want.hit, got.hit);
                    end
                end
            end

            if (cfg_valid && cfg_ready) begin
                hit_threshold = cfg_data;
            end

            if (s_tvalid && s_tready) begin
                act    = action_t'(s_tuser[0]);
                kind   = kind_t'(s_tuser[KIND_BITS:1]);
                sym    = s_tdata[SYM_BITS-1:0];
                first  = s_tdata[2*SYM_BITS-1:SYM_BITS];
                second = s_tdata[3*SYM_BITS-1:2*SYM_BITS];
                third  = s_tdata[4*SYM_BITS-1:3*SYM_BITS];
                if (act == ACT_PUSH) begin
                    unigram_tally[sym] = bumped(unigram_tally[sym]);
                    if (symbols_taken >= 1) begin
                        digram_tally[{last_sym, sym}] = bumped(digram_tally[{last_sym, sym}]);
                        if (last_sym == sym) begin
                            repeat_tally[sym] = bumped(repeat_tally[sym]);
                        end
                    end
                    if (symbols_taken >= 2) begin
                        trigram_tally[{prior_sym, last_sym, sym}] =
                            bumped(trigram_tally[{prior_sym, last_sym, sym}]);
                    end
                    prior_sym = last_sym;
                    last_sym  = sym;
                    if (symbols_taken < 2) begin
                        symbols_taken++;
                    end
                end else begin
                    case (kind)
                        KIND_UNIGRAM: want.count = unigram_tally[first];
                        KIND_DIGRAM:  want.count = digram_tally[{first, second}];
                        KIND_TRIGRAM: want.count = trigram_tally[{first, second, third}];
                        default:      want.count = repeat_tally[first];
                    endcase
                    want.hit = (want.count >= hit_threshold);
                    due_readings.push_back(want);
                end
            end
        end
        readings_pending = due_readings.size();
    end

endmodule

// ===== tb/symbol_ngram_histogram_tb.sv =====
// Top of the n-gram histogram testbench: clock, reset, stimulus and verdict.
// Drives directed, random and repeating symbol streams with random idling on both sides.
// Depends on snh_pkg, symbol_ngram_histogram and symbol_ngram_histogram_checker.
module symbol_ngram_histogram_tb;
    import snh_pkg::*;

    localparam int RUN_LIMIT        = 30_000_000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_STAGES    = 5;
    localparam int STAGE_ITEMS      = 100;
    localparam int REPEAT_PUSHES    = 30;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;
    logic [S_TUSER_BITS-1:0] s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_BITS-1:0]     cfg_data;

    int                  fail_count;
    int                  readings_pending;
    bit                  sender_gaps;
    bit                  reader_stalls;
    bit                  hold_off_pending;
    logic [SYM_BITS-1:0] alphabet_base;

    symbol_ngram_histogram dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    symbol_ngram_histogram_checker ngram_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .readings_pending (readings_pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #RUN_LIMIT;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SYM_BITS-1:0] any_symbol();
        return SYM_BITS'($urandom_range(0, (1 << SYM_BITS) - 1));
    endfunction

    function automatic logic [SYM_BITS-1:0] pick_symbol();
        if ($urandom_range(0, 4) == 0) begin
            return any_symbol();
        end
        return alphabet_base + SYM_BITS'($urandom_range(0, 3));
    endfunction

    task automatic offer_item(input action_t act, input logic [SYM_BITS-1:0] sym,
                              input kind_t kind, input logic [SYM_BITS-1:0] first,
                              input logic [SYM_BITS-1:0] second,
                              input logic [SYM_BITS-1:0] third);
        s_tdata  = {third, second, first, sym};
        s_tuser  = {kind, act};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (sender_gaps && $urandom_range(0, 2) == 0) begin
            s_tvalid = 1'b0;
            repeat (idle_length()) @(negedge aclk);
        end
    endtask

    task automatic push(input logic [SYM_BITS-1:0] sym);
        offer_item(ACT_PUSH, sym, kind_t'($urandom_range(0, 3)), any_symbol(), any_symbol(),
                   any_symbol());
    endtask

    task automatic query(input kind_t kind, input logic [SYM_BITS-1:0] first,
                         input logic [SYM_BITS-1:0] second, input logic [SYM_BITS-1:0] third);
        offer_item(ACT_QUERY, any_symbol(), kind, first, second, third);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        wait (readings_pending == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic [CFG_BITS-1:0] value);
        wait_idle();
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                m_tready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                m_tready = 1'b1;
            end else if (reader_stalls && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat (idle_length()) @(negedge aclk);
                m_tready = 1'b1;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = '0;
        cfg_valid        = 1'b0;
        cfg_data         = '0;
        sender_gaps      = 1'b1;
        reader_stalls    = 1'b1;
        hold_off_pending = 1'b0;
        alphabet_base    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty tables, then a first symbol that must not count as a repeat or digram
        query(KIND_UNIGRAM, 0, 63, 63);
        query(KIND_TRIGRAM, 63, 63, 63);
        push(0);
        push(0);
        push(0);
        push(63);
        push(63);
        query(KIND_UNIGRAM, 0, 0, 0);
        query(KIND_REPEAT, 0, 63, 63);
        query(KIND_DIGRAM, 0, 0, 63);
        query(KIND_TRIGRAM, 0, 0, 0);
        query(KIND_TRIGRAM, 0, 63, 63);
        query(KIND_REPEAT, 63, 0, 0);
        query(KIND_DIGRAM, 63, 0, 0);
        query(KIND_UNIGRAM, 42, 21, 42);
        write_threshold('0);
        query(KIND_TRIGRAM, 63, 63, 63);
        write_threshold(1);
        query(KIND_TRIGRAM, 0, 0, 0);

        for (int stage = 0; stage < RANDOM_STAGES; stage++) begin
            if (stage == 1) begin
                write_threshold(CFG_BITS'($urandom_range(0, (1 << CFG_BITS) - 1)));
            end else begin
                write_threshold(CFG_BITS'($urandom_range(0, 4)));
            end
            alphabet_base = (stage == 2) ? SYM_BITS'(60) : SYM_BITS'($urandom_range(0, 60));
            sender_gaps   = (stage != 1) && (stage != 3);
            reader_stalls = (stage != 3);
            for (int n = 0; n < STAGE_ITEMS; n++) begin
                if (stage == 2 && n == 30) begin
                    sender_gaps      = 1'b0;
                    hold_off_pending = 1'b1;
                end
                if (stage == 2 && n == 60) begin
                    wait_idle();
                    sender_gaps = 1'b1;
                end
                if ($urandom_range(0, 9) < 5) begin
                    push(pick_symbol());
                end else begin
                    query(kind_t'($urandom_range(0, 3)), pick_symbol(), pick_symbol(),
                          pick_symbol());
                end
            end
        end

        // hammer one symbol across every table, back to back
        write_threshold(CFG_BITS'(REPEAT_PUSHES));
        sender_gaps = 1'b0;
        repeat (REPEAT_PUSHES) push(5);
        query(KIND_UNIGRAM, 5, 0, 0);
        query(KIND_REPEAT, 5, 63, 63);
        query(KIND_DIGRAM, 5, 5, 0);
        query(KIND_TRIGRAM, 5, 5, 5);
        query(KIND_UNIGRAM, 4, 5, 5);
        wait_idle();

        if (fail_count == 0 && readings_pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
